// ----- sv/range_add_min_sum_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Range add / min / sum table: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_MIN_SUM_TABLE_UNIT_MACROS_SVH
`define RANGE_ADD_MIN_SUM_TABLE_UNIT_MACROS_SVH

// Check outside of reset.
`define RAMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define RAMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/rams_pkg.sv -----
// ----------------------------------------------------------------------------
// rams_pkg
// Types and constants shared by the range add / min / sum table unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rams_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = 12;
  localparam int unsigned SizeW      = 13;
  localparam int unsigned ValW       = 48;
  localparam int unsigned AnsW       = 64;

  localparam logic [SizeW-1:0] DepthSize = SizeW'(TableDepth);
  localparam logic [SizeW-1:0] SizeReset = SizeW'(TableDepth);

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeAdd  = 2'd1,
    ModeMin  = 2'd2,
    ModeSum  = 2'd3
  } rams_mode_e;

  typedef struct packed {
    rams_mode_e              mode;
    logic [IdxW-1:0]         index_low;
    logic [IdxW-1:0]         index_high;
    logic signed [ValW-1:0]  operand_value;
  } rams_req_t;

  typedef struct packed {
    logic signed [AnsW-1:0]  answer;
    logic                    range_error;
  } rams_rsp_t;

  typedef struct packed {
    logic capture;
    logic init_walk;
    logic step;
    logic load_wr;
    logic emit_err;
    logic emit_ans;
  } rams_cmd_t;

  typedef struct packed {
    logic range_err;
    logic is_load;
    logic is_query;
    logic at_high;
  } rams_sts_t;

endpackage

// ----- sv/range_add_min_sum_table_unit.sv -----
// ----------------------------------------------------------------------------
// range_add_min_sum_table_unit
// Table of 4096 signed 48-bit entries with load, saturating range add,
// range minimum and 64-bit wrapping range sum.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load, or any
// request whose range is invalid, finishes after the range check; an add or
// a query over entries lo..hi reads one entry per cycle through the single
// read port of the entry memory, then drains and finishes. Queries, and invalid
// loads or adds, give one result on rsp_o for exactly one cycle, marked by
// done_o; the receiver cannot stall, so it must take it then. A valid load or
// add gives no result. Entries are undefined until loaded; size_in_use
// (cfg port, reset 4096) may only be written while busy is low.
`timescale 1ns / 1ps

module range_add_min_sum_table_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rams_pkg::rams_req_t        req_i,
  output logic                       done_o,
  output rams_pkg::rams_rsp_t        rsp_o,
  input  logic                       cfg_we_i,
  input  logic [rams_pkg::SizeW-1:0] cfg_wdata_i
);
  import rams_pkg::*;

  rams_cmd_t cmd;
  rams_sts_t sts;

  rams_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rams_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- sv/rams_ctrl.sv -----
// ----------------------------------------------------------------------------
// rams_ctrl
// Sequencer: checks the request, walks the range, issues the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rams_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  rams_pkg::rams_sts_t sts_i,
  output rams_pkg::rams_cmd_t cmd_o
);
  import rams_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StWalk,
    StDrain,
    StFinish
  } state_e;

  state_e state_q;
  logic   done_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.capture = start;
      end
      StCheck: begin
        if (sts_i.range_err) begin
          cmd_o.emit_err = 1'b1;
        end else if (sts_i.is_load) begin
          cmd_o.load_wr = 1'b1;
        end else begin
          cmd_o.init_walk = 1'b1;
        end
      end
      StWalk: begin
        cmd_o.step = 1'b1;
      end
      StDrain: begin
      end
      StFinish: begin
        cmd_o.emit_ans = sts_i.is_query;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) state_q <= StCheck;
        end
        StCheck: begin
          if (sts_i.range_err) begin
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else if (sts_i.is_load) begin
            state_q <= StIdle;
          end else begin
            state_q <= StWalk;
          end
        end
        StWalk: begin
          if (sts_i.at_high) state_q <= StDrain;
        end
        StDrain: begin
          state_q <= StFinish;
        end
        StFinish: begin
          done_q  <= sts_i.is_query;
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;

endmodule

// ----- sv/rams_dp.sv -----
// ----------------------------------------------------------------------------
// rams_dp
// Entry memory, size register, range check, saturating add, min and sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rams_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rams_pkg::SizeW-1:0]     cfg_wdata_i,
  input  rams_pkg::rams_req_t            req_i,
  input  rams_pkg::rams_cmd_t            cmd_i,
  output rams_pkg::rams_sts_t            sts_o,
  output rams_pkg::rams_rsp_t            rsp_o
);
  import rams_pkg::*;

  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  logic [ValW-1:0]  mem_q [TableDepth];

  rams_req_t        req_q;
  rams_rsp_t        rsp_q;
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] size_act;
  logic [IdxW-1:0]  addr_q;
  logic [IdxW-1:0]  rd_addr_q;
  logic [ValW-1:0]  rd_data_q;
  logic             rd_vld_q;
  logic             first_q;
  logic [AnsW-1:0]  acc_q;

  logic [ValW:0]    add_ext;
  logic [ValW-1:0]  add_sat;
  logic [AnsW-1:0]  rd_sext;
  logic             rd_less;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [ValW-1:0]  wr_data;
  logic             err_load;
  logic             err_range;

  assign size_act  = (size_q > DepthSize) ? DepthSize : size_q;
  assign err_load  = ({1'b0, req_q.index_low} >= size_act);
  assign err_range = (req_q.index_low > req_q.index_high) ||
                     ({1'b0, req_q.index_high} >= size_act);

  assign sts_o.is_load   = (req_q.mode == ModeLoad);
  assign sts_o.is_query  = (req_q.mode == ModeMin) || (req_q.mode == ModeSum);
  assign sts_o.range_err = sts_o.is_load ? err_load : err_range;
  assign sts_o.at_high   = (addr_q == req_q.index_high);

  assign add_ext = {rd_data_q[ValW-1], rd_data_q} +
                   {req_q.operand_value[ValW-1], req_q.operand_value};
  assign add_sat = (add_ext[ValW] != add_ext[ValW-1]) ?
                   (add_ext[ValW] ? ValMin : ValMax) : add_ext[ValW-1:0];
  assign rd_sext = {{(AnsW-ValW){rd_data_q[ValW-1]}}, rd_data_q};
  assign rd_less = ($signed(rd_data_q) < $signed(acc_q[ValW-1:0]));

  assign wr_en   = cmd_i.load_wr || (rd_vld_q && (req_q.mode == ModeAdd));
  assign wr_addr = cmd_i.load_wr ? req_q.index_low : rd_addr_q;
  assign wr_data = cmd_i.load_wr ? req_q.operand_value : add_sat;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.step) rd_data_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.step) rd_addr_q <= addr_q;
    if (cmd_i.init_walk) begin
      addr_q <= req_q.index_low;
      acc_q  <= '0;
    end else begin
      if (cmd_i.step) addr_q <= addr_q + IdxW'(1);
      if (rd_vld_q) begin
        unique case (req_q.mode)
          ModeMin: begin
            if (first_q || rd_less) acc_q <= rd_sext;
          end
          ModeSum: begin
            acc_q <= acc_q + rd_sext;
          end
          default: begin
          end
        endcase
      end
    end
    if (cmd_i.emit_err) begin
      rsp_q.answer      <= '0;
      rsp_q.range_error <= 1'b1;
    end else if (cmd_i.emit_ans) begin
      rsp_q.answer      <= acc_q;
      rsp_q.range_error <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SizeReset;
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      rd_vld_q <= cmd_i.step;
      if (cmd_i.init_walk) begin
        first_q <= 1'b1;
      end else if (rd_vld_q) begin
        first_q <= 1'b0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- sv/rams_chk.sv -----
// ----------------------------------------------------------------------------
// rams_chk
// Port-level checks for the range add / min / sum table unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "range_add_min_sum_table_unit_macros.svh"

module rams_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input rams_pkg::rams_rsp_t rsp_o
);
  import rams_pkg::*;

  `RAMS_ASSERT(a_busy_after_req, start && !busy |=> busy, "request not followed by busy")
  `RAMS_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  `RAMS_ASSERT(a_done_single, done_o |=> !done_o, "two results in a row")
  `RAMS_ASSERT(a_err_zero, done_o && rsp_o.range_error |-> rsp_o.answer == '0,
               "error result with nonzero answer")
  `RAMS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !busy && !done_o, "activity in reset")

endmodule

bind range_add_min_sum_table_unit rams_chk u_rams_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ----- test/tb_range_add_min_sum_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_range_add_min_sum_table_unit
// Drives load, range add, range minimum and range sum requests into the table
// unit under several table sizes and sender idle rates. A local copy of the
// table predicts every answer and error result, and each result on rsp_o is
// compared field by field with the oldest prediction. Adds and queries only
// touch entries that were loaded first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_add_min_sum_table_unit;
  import rams_pkg::*;

  localparam logic [ValW-1:0] ValMaxBits = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] ValMinBits = {1'b1, {(ValW-1){1'b0}}};
  localparam int unsigned DrainCycles = TableDepth + 8;
  localparam int unsigned QuietLimit  = 8 * TableDepth;

  typedef struct {
    rams_req_t req;
    bit        drain_first;
  } pending_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  rams_req_t           req_i;
  logic                done_o;
  rams_rsp_t           rsp_o;
  logic                cfg_we_i;
  logic [SizeW-1:0]    cfg_wdata_i;

  pending_req_t        pending_reqs[$];
  rams_rsp_t           awaited_answers[$];
  logic signed [ValW-1:0] entry_mirror [TableDepth];
  logic [SizeW-1:0]    size_mirror;
  logic [SizeW-1:0]    plan_size;
  bit                  plan_loaded [TableDepth];
  int unsigned         send_idle_pct;
  int unsigned         fail_count;
  int unsigned         quiet_cycles;
  bit                  req_fired;

  range_add_min_sum_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit table_outcome(input rams_req_t r, output rams_rsp_t rsp);
    int unsigned eff;
    int unsigned lo;
    int unsigned hi;
    logic [ValW:0] wide;
    logic signed [ValW-1:0] low_val;
    logic [AnsW-1:0] total;
    eff = (size_mirror > DepthSize) ? TableDepth : size_mirror;
    lo = r.index_low;
    hi = r.index_high;
    rsp.answer = '0;
    rsp.range_error = 1'b1;
    if (r.mode == ModeLoad) begin
      if (lo >= eff) return 1'b1;
      entry_mirror[lo] = r.operand_value;
      return 1'b0;
    end
    if (lo > hi || hi >= eff) return 1'b1;
    rsp.range_error = 1'b0;
    case (r.mode)
      ModeAdd: begin
        for (int unsigned i = lo; i <= hi; i++) begin
          wide = {entry_mirror[i][ValW-1], entry_mirror[i]} +
                 {r.operand_value[ValW-1], r.operand_value};
          if (wide[ValW] != wide[ValW-1]) begin
            entry_mirror[i] = wide[ValW] ? ValMinBits : ValMaxBits;
          end else begin
            entry_mirror[i] = wide[ValW-1:0];
          end
        end
        return 1'b0;
      end
      ModeMin: begin
        low_val = entry_mirror[lo];
        for (int unsigned i = lo + 1; i <= hi; i++) begin
          if (entry_mirror[i] < low_val) low_val = entry_mirror[i];
        end
        rsp.answer = {{(AnsW-ValW){low_val[ValW-1]}}, low_val};
      end
      default: begin
        total = '0;
        for (int unsigned i = lo; i <= hi; i++) begin
          total = total + {{(AnsW-ValW){entry_mirror[i][ValW-1]}}, entry_mirror[i]};
        end
        rsp.answer = total;
      end
    endcase
    return 1'b1;
  endfunction

  // Driver: hold a request until taken, then advance or idle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || req_fired) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_reqs[0].drain_first && (awaited_answers.size() != 0 || busy))) begin
          req_i <= pending_reqs[0].req;
          void'(pending_reqs.pop_front());
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results, predict accepted requests, watch for stalls.
  always @(posedge clk_i) begin
    rams_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_answers.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, answer %0d range_error %0b",
                   $time, rsp_o.answer, rsp_o.range_error);
        end else begin
          want = awaited_answers.pop_front();
          if (rsp_o.answer !== want.answer) begin
            fail_count++;
            $display("%0t: answer mismatch, expected %0d, got %0d",
                     $time, want.answer, rsp_o.answer);
          end
          if (rsp_o.range_error !== want.range_error) begin
            fail_count++;
            $display("%0t: range_error mismatch, expected %0b, got %0b",
                     $time, want.range_error, rsp_o.range_error);
          end
        end
      end
      req_fired = start && !busy;
      if (req_fired) begin
        if (table_outcome(req_i, want)) awaited_answers.push_back(want);
      end
      if (req_fired || done_o || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no progress", $time);
        $display("tb_range_add_min_sum_table_unit failed");
        $finish;
      end
    end
  end

  function automatic int unsigned plan_eff();
    return (plan_size > DepthSize) ? TableDepth : plan_size;
  endfunction

  function automatic logic [ValW-1:0] rand48();
    logic signed [ValW-1:0] s;
    case ($urandom_range(9))
      0: return ValMaxBits;
      1: return ValMinBits;
      2: return '0;
      3: return '1;
      4, 5, 6: begin
        s = $urandom_range(2000);
        s = s - 1000;
        return s;
      end
      default: return ValW'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic queue_req(input rams_mode_e m, input int unsigned lo, input int unsigned hi,
                           input logic [ValW-1:0] val, input bit drain = 1'b0);
    pending_req_t item;
    item.req.mode = m;
    item.req.index_low = IdxW'(lo);
    item.req.index_high = IdxW'(hi);
    item.req.operand_value = val;
    item.drain_first = drain;
    pending_reqs.push_back(item);
    if (m == ModeLoad && lo < plan_eff()) plan_loaded[lo] = 1'b1;
  endtask

  // Load any untouched entry of a valid range, then issue the range request.
  task automatic queue_range(input rams_mode_e m, input int unsigned lo, input int unsigned hi,
                             input logic [ValW-1:0] val, input bit drain);
    for (int unsigned i = lo; i <= hi; i++) begin
      if (!plan_loaded[i]) queue_req(ModeLoad, i, $urandom_range(TableDepth-1), rand48());
    end
    queue_req(m, lo, hi, val, drain);
  endtask

  task automatic queue_bad_range();
    rams_mode_e m;
    int unsigned eff;
    int unsigned lo;
    int unsigned hi;
    eff = plan_eff();
    m = rams_mode_e'($urandom_range(3));
    if (eff < TableDepth && ($urandom_range(1) == 0 || m == ModeLoad)) begin
      hi = $urandom_range(TableDepth-1, eff);
      lo = (m == ModeLoad) ? hi : $urandom_range(hi, 0);
    end else begin
      if (m == ModeLoad) m = ModeSum;
      hi = $urandom_range(TableDepth-2, 0);
      lo = $urandom_range(TableDepth-1, hi+1);
    end
    queue_req(m, lo, hi, rand48());
  endtask

  task automatic queue_walk();
    int unsigned eff;
    int unsigned lo;
    int unsigned hi;
    rams_mode_e m;
    eff = plan_eff();
    if (eff > 64 && $urandom_range(9) != 0) begin
      lo = $urandom_range(31, 0);
    end else begin
      lo = $urandom_range(eff-1, 0);
    end
    hi = lo + (($urandom_range(9) == 0) ? $urandom_range(31, 0) : $urandom_range(7, 0));
    if (hi > eff - 1) hi = eff - 1;
    case ($urandom_range(2))
      0: m = ModeAdd;
      1: m = ModeMin;
      default: m = ModeSum;
    endcase
    queue_range(m, lo, hi, rand48(), $urandom_range(29) == 0);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        queue_req(ModeLoad, $urandom_range(plan_eff()-1), $urandom_range(TableDepth-1),
                  rand48());
      end else if (pick < 30) begin
        queue_bad_range();
      end else begin
        queue_walk();
      end
    end
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || awaited_answers.size() != 0 || start) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [SizeW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_mirror = value;
    plan_size = value;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    size_mirror = SizeReset;
    plan_size = SizeReset;
    send_idle_pct = 32;
    fail_count = 0;
    quiet_cycles = 0;
    req_fired = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    queue_req(ModeLoad, 0, 0, ValMaxBits);
    queue_req(ModeLoad, 1, 0, ValMinBits);
    queue_req(ModeLoad, 2, TableDepth-1, '0);
    queue_req(ModeLoad, 3, 0, '1);
    queue_req(ModeLoad, TableDepth-1, 0, {(ValW/2){2'b01}});
    queue_req(ModeLoad, TableDepth-2, 0, {(ValW/2){2'b10}});
    queue_req(ModeAdd, 0, 0, ValW'(1));
    queue_req(ModeAdd, 1, 1, '1);
    queue_req(ModeAdd, 2, 3, ValMaxBits);
    queue_req(ModeMin, 0, 3, '1, 1'b1);
    queue_req(ModeSum, 0, 3, ValMaxBits);
    queue_req(ModeAdd, TableDepth-2, TableDepth-1, ValMinBits);
    queue_req(ModeSum, TableDepth-2, TableDepth-1, '0);
    queue_req(ModeMin, 5, 2, '0);
    queue_req(ModeAdd, 3, 1, ValW'(7));
    queue_req(ModeSum, TableDepth-1, 0, '0);
    queue_random(20);

    settle();
    send_idle_pct = 57;
    write_size(SizeW'(1));
    queue_req(ModeLoad, 0, TableDepth-1, ValW'(5));
    queue_req(ModeLoad, 1, 0, ValW'(9));
    queue_req(ModeSum, 0, 0, '1);
    queue_req(ModeAdd, 0, 1, ValW'(3));

    settle();
    write_size('0);
    queue_req(ModeLoad, 0, 0, ValW'(4));
    queue_req(ModeMin, 0, 0, '0);

    settle();
    write_size('1);
    queue_req(ModeMin, TableDepth-2, TableDepth-1, '0);
    queue_req(ModeAdd, TableDepth-1, TableDepth-1, ValW'(1));
    queue_req(ModeSum, 0, 1, '0);

    settle();
    write_size(SizeW'(37));
    queue_random(20);

    settle();
    send_idle_pct = 0;
    write_size(DepthSize);
    queue_random(20);

    settle();
    if (fail_count == 0) begin
      $display("tb_range_add_min_sum_table_unit passed");
    end else begin
      $display("tb_range_add_min_sum_table_unit failed");
    end
    $finish;
  end

endmodule
